// File: rtl/npe_pkg.sv
// npe_pkg: shared types and constants for the next permutation engine
// beat structs, configuration register indexes, datapath command and status
// no dependencies
package npe_pkg;

    localparam int MAX_LEN_DEF   = 16;
    localparam int ELEM_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int LEN_CFG_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'd1;

    // operation codes of an input beat
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  position;
        logic [15:0] element_value;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] out_value;
        logic [3:0]  out_index;
        logic        last_of_run;
        logic        finished;
    } out_beat_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_START,
        DP_FIN,
        DP_SCAN_RD,
        DP_SCAN_STEP,
        DP_PIVOT,
        DP_TGT_STEP,
        DP_SWAP_A,
        DP_SWAP_B,
        DP_REV_A,
        DP_REV_B,
        DP_DONE,
        DP_EMIT_OUT
    } dp_cmd_t;

    typedef struct packed {
        logic len_lt2;   // sequence too short to permute
        logic less_ab;   // left read below right read
        logic less_pb;   // pivot value below right read
        logic i_one;     // scan reached the front
        logic rev_more;  // reverse pointers not yet crossed
        logic out_free;  // output register can take a beat
        logic last;      // current emit beat is the final one
    } dp_status_t;

endpackage

// File: rtl/npe_ctrl.sv
// npe_ctrl: sequencer for load, pivot scan, target scan, swap, suffix reverse and emit
// drives npe_pkg::dp_cmd_t commands into npe_dpath, reads npe_pkg::dp_status_t
// depends on npe_pkg
module npe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  npe_pkg::dp_status_t st,
    output npe_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_TGT,
        S_SWAP,
        S_REV,
        S_REV2,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = npe_pkg::DP_NOP;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation == npe_pkg::OP_LOAD) begin
                        cmd = npe_pkg::DP_LOAD;
                    end else begin
                        cmd        = npe_pkg::DP_START;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (st.len_lt2) begin
                    cmd        = npe_pkg::DP_FIN;
                    state_next = S_EMIT;
                end else begin
                    cmd        = npe_pkg::DP_SCAN_RD;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (st.less_ab) begin
                    cmd        = npe_pkg::DP_PIVOT;
                    state_next = S_TGT;
                end else if (st.i_one) begin
                    cmd        = npe_pkg::DP_FIN;
                    state_next = S_EMIT;
                end else begin
                    cmd = npe_pkg::DP_SCAN_STEP;
                end
            end
            S_TGT: begin
                if (st.less_pb) begin
                    cmd        = npe_pkg::DP_SWAP_A;
                    state_next = S_SWAP;
                end else begin
                    cmd = npe_pkg::DP_TGT_STEP;
                end
            end
            S_SWAP: begin
                cmd        = npe_pkg::DP_SWAP_B;
                state_next = S_REV;
            end
            S_REV: begin
                if (st.rev_more) begin
                    cmd        = npe_pkg::DP_REV_A;
                    state_next = S_REV2;
                end else begin
                    cmd        = npe_pkg::DP_DONE;
                    state_next = S_EMIT;
                end
            end
            S_REV2: begin
                cmd        = npe_pkg::DP_REV_B;
                state_next = S_REV;
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd = npe_pkg::DP_EMIT_OUT;
                    if (st.last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/npe_dpath.sv
// npe_dpath: element store, read registers, scan pointers, config and output register
// executes one npe_pkg::dp_cmd_t per cycle and reports npe_pkg::dp_status_t
// depends on npe_pkg
module npe_dpath #(
    parameter int MAX_LEN   = npe_pkg::MAX_LEN_DEF,
    parameter int ELEM_BITS = npe_pkg::ELEM_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [npe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [npe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  npe_pkg::in_beat_t                s_data,
    input  npe_pkg::dp_cmd_t                 cmd,
    output npe_pkg::dp_status_t              st,
    output logic                             m_valid,
    input  logic                             m_ready,
    output npe_pkg::out_beat_t               m_data
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int DEPTH = 2 ** IDX_W;

    localparam logic [IDX_W-1:0]     IDX_ONE  = IDX_W'(1);
    localparam logic [IDX_W-1:0]     IDX_TWO  = IDX_W'(2);
    localparam logic [LEN_W-1:0]     LEN_ONE  = LEN_W'(1);
    localparam logic [LEN_W-1:0]     LEN_MAX  = LEN_W'(MAX_LEN);
    localparam logic [ELEM_BITS-1:0] SIGN_BIT = ELEM_BITS'(1) << (ELEM_BITS - 1);

    logic [ELEM_BITS-1:0] mem [DEPTH];

    logic [npe_pkg::LEN_CFG_W-1:0] cfg_len_reg;
    logic                          cfg_signed_reg;

    logic [ELEM_BITS-1:0] rd_a_reg, rd_b_reg, pval_reg;
    logic [IDX_W-1:0]     i_reg, i_next, j_reg, j_next, piv_reg, piv_next;
    logic [LEN_W-1:0]     len_reg, len_next, k_reg, k_next;
    logic                 fin_reg, fin_next;
    logic                 out_valid_reg;
    npe_pkg::out_beat_t   out_beat_reg;

    logic [IDX_W-1:0]     addr_a, addr_b, waddr;
    logic                 cap_a, cap_b, we;
    logic [ELEM_BITS-1:0] wdata;
    logic [LEN_W-1:0]     len_sat, len_dec, k_inc;
    logic [IDX_W-1:0]     last_idx;
    logic                 pos_ok;
    logic                 out_load;
    logic [ELEM_BITS-1:0] cmp_a, cmp_b, cmp_p;

    // saturate the configured length to MAX_LEN
    assign len_sat  = (int'(cfg_len_reg) > MAX_LEN) ? LEN_MAX : LEN_W'(cfg_len_reg);
    assign len_dec  = len_reg - LEN_ONE;
    assign last_idx = len_dec[IDX_W-1:0];
    assign k_inc    = k_reg + LEN_ONE;
    assign pos_ok   = (int'(s_data.position) < MAX_LEN);

    // signed order: flip the sign bit, then compare unsigned
    assign cmp_a = cfg_signed_reg ? (rd_a_reg ^ SIGN_BIT) : rd_a_reg;
    assign cmp_b = cfg_signed_reg ? (rd_b_reg ^ SIGN_BIT) : rd_b_reg;
    assign cmp_p = cfg_signed_reg ? (pval_reg ^ SIGN_BIT) : pval_reg;

    assign st.len_lt2  = (len_reg < LEN_W'(2));
    assign st.less_ab  = (cmp_a < cmp_b);
    assign st.less_pb  = (cmp_p < cmp_b);
    assign st.i_one    = (i_reg == IDX_ONE);
    assign st.rev_more = (i_reg < j_reg);
    assign st.out_free = !out_valid_reg || m_ready;
    assign st.last     = (len_reg == '0) || (k_inc == len_reg);

    assign out_load = (cmd == npe_pkg::DP_EMIT_OUT);

    always_comb begin
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        piv_next = piv_reg;
        len_next = len_reg;
        fin_next = fin_reg;
        addr_a   = i_reg;
        addr_b   = j_reg;
        cap_a    = 1'b0;
        cap_b    = 1'b0;
        we       = 1'b0;
        waddr    = i_reg;
        wdata    = rd_b_reg;
        case (cmd)
            npe_pkg::DP_LOAD: begin
                we    = pos_ok;
                waddr = IDX_W'(s_data.position);
                wdata = ELEM_BITS'(s_data.element_value);
            end
            npe_pkg::DP_START: begin
                len_next = len_sat;
                i_next   = IDX_W'(len_sat - LEN_ONE);
            end
            npe_pkg::DP_SCAN_RD: begin
                addr_a = i_reg - IDX_ONE;
                addr_b = i_reg;
                cap_a  = 1'b1;
                cap_b  = 1'b1;
            end
            npe_pkg::DP_SCAN_STEP: begin
                // step left and fetch the next adjacent pair
                i_next = i_reg - IDX_ONE;
                addr_a = i_reg - IDX_TWO;
                addr_b = i_reg - IDX_ONE;
                cap_a  = 1'b1;
                cap_b  = 1'b1;
            end
            npe_pkg::DP_PIVOT: begin
                piv_next = i_reg - IDX_ONE;
                j_next   = last_idx;
                addr_b   = last_idx;
                cap_b    = 1'b1;
            end
            npe_pkg::DP_TGT_STEP: begin
                j_next = j_reg - IDX_ONE;
                addr_b = j_reg - IDX_ONE;
                cap_b  = 1'b1;
            end
            npe_pkg::DP_SWAP_A: begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = pval_reg;
            end
            npe_pkg::DP_SWAP_B: begin
                // pivot gets the target value, then fetch the suffix ends
                we     = 1'b1;
                waddr  = piv_reg;
                wdata  = rd_b_reg;
                j_next = last_idx;
                addr_a = i_reg;
                addr_b = last_idx;
                cap_a  = 1'b1;
                cap_b  = 1'b1;
            end
            npe_pkg::DP_REV_A: begin
                we    = 1'b1;
                waddr = i_reg;
                wdata = rd_b_reg;
            end
            npe_pkg::DP_REV_B: begin
                we     = 1'b1;
                waddr  = j_reg;
                wdata  = rd_a_reg;
                i_next = i_reg + IDX_ONE;
                j_next = j_reg - IDX_ONE;
                addr_a = i_reg + IDX_ONE;
                addr_b = j_reg - IDX_ONE;
                cap_a  = 1'b1;
                cap_b  = 1'b1;
            end
            npe_pkg::DP_FIN, npe_pkg::DP_DONE: begin
                fin_next = (cmd == npe_pkg::DP_FIN);
                k_next   = '0;
                addr_a   = '0;
                cap_a    = 1'b1;
            end
            npe_pkg::DP_EMIT_OUT: begin
                k_next = k_inc;
                addr_a = k_inc[IDX_W-1:0];
                cap_a  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // element store, one write and two registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cap_a) begin
            rd_a_reg <= mem[addr_a];
        end
        if (cap_b) begin
            rd_b_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        piv_reg <= piv_next;
        if (cmd == npe_pkg::DP_PIVOT) begin
            pval_reg <= rd_a_reg;
        end
        if (out_load) begin
            out_beat_reg.out_value   <= (len_reg == '0) ? 16'd0 : 16'(rd_a_reg);
            out_beat_reg.out_index   <= 4'(k_reg);
            out_beat_reg.last_of_run <= st.last;
            out_beat_reg.finished    <= fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_len_reg    <= '0;
            cfg_signed_reg <= 1'b0;
            len_reg        <= '0;
            fin_reg        <= 1'b1;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == npe_pkg::CFG_LENGTH) begin
                cfg_len_reg <= cfg_data[npe_pkg::LEN_CFG_W-1:0];
            end
            if (cfg_we && cfg_index == npe_pkg::CFG_SIGNED) begin
                cfg_signed_reg <= cfg_data[0];
            end
            len_reg <= len_next;
            fin_reg <= fin_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (int'(waddr) < MAX_LEN))
        else $error("store write outside the sequence depth");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("result loaded over an untaken beat");

    a_rev_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == npe_pkg::DP_REV_A) |-> (i_reg < j_reg && piv_reg < i_reg))
        else $error("reverse pointers out of order");

    a_advance_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == npe_pkg::DP_DONE) |-> !st.len_lt2)
        else $error("permutation produced for a sequence shorter than two");

endmodule

// File: rtl/next_permutation_engine.sv
// next_permutation_engine: top level, steps a stored sequence to its next permutation
// instantiates npe_ctrl and npe_dpath, depends on npe_pkg
//
// Usage: s_ channel (valid/ready) takes load and advance beats. A load beat
// writes element_value at position and gives no result; loads
// to a position at or above MAX_LEN are dropped. An advance beat works on the
// first min(length_in_use, MAX_LEN) elements: it scans left for the pivot,
// scans left for the swap target, swaps, reverses the suffix and then sends
// every element on the m_ channel, in order, with last_of_run on the final beat.
// finished is set when no next permutation exists; the store is then unchanged.
// A length of zero gives a single beat with value 0, last_of_run and finished.
// s_ready is high only while no advance is in progress; the last result can
// still wait in the output register while the next beat is taken.
// A stalled m_ready holds the emit pass, one result beat a cycle otherwise.
// cfg_we writes register cfg_index (0 length, 1 signed order); the user must do
// this only while idle, which the block itself does not enforce.
// Reset clears the configuration and the handshakes and sets the finished flag;
// the element store holds nothing defined until it is loaded.
module next_permutation_engine #(
    parameter int MAX_LEN   = npe_pkg::MAX_LEN_DEF,
    parameter int ELEM_BITS = npe_pkg::ELEM_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [npe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [npe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  npe_pkg::in_beat_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output npe_pkg::out_beat_t             m_data
);

    npe_pkg::dp_cmd_t    cmd;
    npe_pkg::dp_status_t st;

    npe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_data.operation),
        .st          (st),
        .cmd         (cmd)
    );

    npe_dpath #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: dv/next_permutation_engine_tb.sv
// next_permutation_engine_tb: self-checking bench for the permutation stepper
// directed beat table plus random load/advance traffic under backpressure, checked
// against a behavioral next-permutation predictor; depends on npe_pkg and the rtl
module next_permutation_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_DEPTH     = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIR_ROWS      = 24;
    localparam int PHASES        = 12;
    localparam int PHASE_BEATS   = 16;
    localparam int REPORT_MAX    = 10;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [npe_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [npe_pkg::CFG_DATA_W-1:0] reg_val;
        npe_pkg::in_beat_t              beat;
        logic                           typed;
        npe_pkg::out_beat_t             typed_res;
    } stim_row_t;

    localparam npe_pkg::out_beat_t NO_RES  = '0;
    localparam npe_pkg::in_beat_t  NO_BEAT = '0;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [npe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [npe_pkg::CFG_DATA_W-1:0] cfg_data;
    logic      s_valid;
    logic      s_ready;
    npe_pkg::in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    npe_pkg::out_beat_t m_data;

    next_permutation_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // predictor state
    logic [15:0]           seq_store [SEQ_DEPTH];
    logic [SEQ_DEPTH-1:0]  loaded_mask;
    logic [4:0]            seq_length;
    logic                  seq_signed;
    npe_pkg::out_beat_t    pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int cycle_count;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_ADVANCE, 4'd0, 16'h0000},
          1'b1, '{16'h0000, 4'd0, 1'b1, 1'b1}},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd0, 16'hFFFF},
          1'b0, NO_RES},
        '{ROW_REG,  npe_pkg::CFG_LENGTH, 5'd1, NO_BEAT, 1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_ADVANCE, 4'd9, 16'h1234},
          1'b1, '{16'hFFFF, 4'd0, 1'b1, 1'b1}},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd1, 16'h0000},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd2, 16'h8000},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd3, 16'h7FFF},
          1'b0, NO_RES},
        '{ROW_REG,  npe_pkg::CFG_LENGTH, 5'd4, NO_BEAT, 1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_ADVANCE, 4'd0, 16'h0000},
          1'b0, NO_RES},
        '{ROW_REG,  npe_pkg::CFG_SIGNED, 5'd1, NO_BEAT, 1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_ADVANCE, 4'd15, 16'hFFFF},
          1'b0, NO_RES},
        // descending in signed order: no next permutation
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd0, 16'h7FFF},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd1, 16'h0001},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd2, 16'hFFFF},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd3, 16'h8000},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_ADVANCE, 4'd0, 16'h0000},
          1'b0, NO_RES},
        '{ROW_REG,  npe_pkg::CFG_SIGNED, 5'd0, NO_BEAT, 1'b0, NO_RES},
        // repeated values
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd0, 16'h0003},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd1, 16'h0005},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd2, 16'h0005},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd3, 16'h0003},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_ADVANCE, 4'd0, 16'h0000},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_LOAD, 4'd15, 16'hFFFF},
          1'b0, NO_RES},
        '{ROW_BEAT, npe_pkg::CFG_LENGTH, 5'd0, '{npe_pkg::OP_ADVANCE, 4'd0, 16'h0000},
          1'b0, NO_RES}
    };

    int               phase_len [PHASES] = '{16, 3, 31, 2, 0, 5, 1, 4, 16, 7, 3, 12};
    logic [PHASES-1:0] phase_signed      = 12'b1010_0110_1010;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit ordered_below(input logic [15:0] a, input logic [15:0] b);
        if (seq_signed)
            return $signed(a) < $signed(b);
        return a < b;
    endfunction

    // steps the first n entries to the next permutation, 0 when none exists
    function automatic bit permute_forward(input int n);
        int i;
        int j;
        logic [15:0] t;
        if (n < 2)
            return 1'b0;
        i = n - 1;
        while (i > 0 && !ordered_below(seq_store[i-1], seq_store[i]))
            i--;
        if (i == 0)
            return 1'b0;
        j = n - 1;
        while (j > i && !ordered_below(seq_store[i-1], seq_store[j]))
            j--;
        t = seq_store[i-1];
        seq_store[i-1] = seq_store[j];
        seq_store[j] = t;
        j = n - 1;
        while (i < j) begin
            t = seq_store[i];
            seq_store[i] = seq_store[j];
            seq_store[j] = t;
            i++;
            j--;
        end
        return 1'b1;
    endfunction

    function automatic int active_length();
        return (seq_length > SEQ_DEPTH) ? SEQ_DEPTH : int'(seq_length);
    endfunction

    function automatic void predict_beat(input npe_pkg::in_beat_t beat);
        int n;
        logic fin;
        npe_pkg::out_beat_t r;
        if (beat.operation == npe_pkg::OP_LOAD) begin
            seq_store[beat.position] = beat.element_value;
            loaded_mask[beat.position] = 1'b1;
            return;
        end
        n = active_length();
        fin = !permute_forward(n);
        if (n == 0) begin
            r = '{16'h0000, 4'd0, 1'b1, 1'b1};
            pending_results.push_back(r);
        end
        for (int k = 0; k < n; k++) begin
            r.out_value   = seq_store[k];
            r.out_index   = 4'(k);
            r.last_of_run = (k == n - 1);
            r.finished    = fin;
            pending_results.push_back(r);
        end
    endfunction

    task automatic send_beat(input npe_pkg::in_beat_t beat, input logic typed,
                             input npe_pkg::out_beat_t res);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        predict_beat(beat);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(res);
        end
    endtask

    task automatic write_reg(input logic [npe_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= npe_pkg::CFG_DATA_W'(val);
        @(posedge aclk);
        if (idx == npe_pkg::CFG_LENGTH)
            seq_length = 5'(val);
        else
            seq_signed = val[0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // hold off the sender until every expected beat has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic npe_pkg::in_beat_t random_beat(input int n);
        npe_pkg::in_beat_t b;
        b.position      = 4'($urandom_range(15));
        b.element_value = 16'($urandom);
        if ($urandom_range(99) < 60) begin
            b.operation = npe_pkg::OP_ADVANCE;
            return b;
        end
        b.operation = npe_pkg::OP_LOAD;
        if (n > 0 && $urandom_range(99) < 70)
            b.position = 4'($urandom_range(n - 1));
        case ($urandom_range(3))
            0, 1: b.element_value = 16'($urandom_range(3));    // force repeated values
            2: begin
                case ($urandom_range(3))
                    0: b.element_value = 16'h8000;
                    1: b.element_value = 16'h7FFF;
                    2: b.element_value = 16'hFFFF;
                    default: b.element_value = 16'h0000;
                endcase
            end
            default: ;
        endcase
        return b;
    endfunction

    task automatic report_fail(input string what, input npe_pkg::out_beat_t want,
                               input npe_pkg::out_beat_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t %s: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                     $realtime, what, want.out_value, want.out_index, want.last_of_run,
                     want.finished, got.out_value, got.out_index, got.last_of_run,
                     got.finished);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        npe_pkg::out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_fail("unexpected beat", '0, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.out_value !== want.out_value ||
                    m_data.out_index !== want.out_index ||
                    m_data.last_of_run !== want.last_of_run ||
                    m_data.finished !== want.finished)
                    report_fail("result mismatch", want, m_data);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        mismatches  = 0;
        cycle_count = 0;
        seq_length  = '0;
        seq_signed  = 1'b0;
        loaded_mask = '0;
        for (int k = 0; k < SEQ_DEPTH; k++)
            seq_store[k] = '0;
        send_idle_pct = 27;
        recv_idle_pct = 61;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REG) begin
                wait_drained();
                write_reg(directed_rows[r].reg_idx, int'(directed_rows[r].reg_val));
            end else begin
                send_beat(directed_rows[r].beat, directed_rows[r].typed,
                          directed_rows[r].typed_res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p == 4) begin
                send_idle_pct = 61;
                recv_idle_pct = 27;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(npe_pkg::CFG_LENGTH, phase_len[p]);
            write_reg(npe_pkg::CFG_SIGNED, int'(phase_signed[p]));
            n = active_length();
            // every entry the advance will read gets loaded first
            for (int k = 0; k < n; k++)
                if (!loaded_mask[k])
                    send_beat('{npe_pkg::OP_LOAD, 4'(k), 16'($urandom)}, 1'b0, NO_RES);
            for (int k = 0; k < PHASE_BEATS; k++)
                send_beat(random_beat(n), 1'b0, NO_RES);
        end

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
